// ===== rtl/core/tfms_pkg.sv =====
package tfms_pkg;

    localparam int MAX_MODES_DEF  = 64;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 24;
    localparam int MODES_W        = 7;

    localparam logic [1:0] KIND_WAVE  = 2'd0;
    localparam logic [1:0] KIND_POL1  = 2'd1;
    localparam logic [1:0] KIND_POL2  = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    localparam logic signed [33:0] CORDIC_ONE = 34'sd652032874;

    typedef struct packed {
        logic clear;
        logic load_pos;
        logic rd_en;
        logic mode_start;
        logic cordic_init;
        logic cordic_step;
        logic term_calc;
        logic acc_add;
        logic sat_out;
    } tfms_cmd_t;

    typedef struct packed {
        logic last_step;
    } tfms_status_t;

    function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
        logic signed [33:0] r;
        begin
            unique case (i)
                5'd0: r = 34'sd536870912;
                5'd1: r = 34'sd316933406;
                5'd2: r = 34'sd167458907;
                5'd3: r = 34'sd85004756;
                5'd4: r = 34'sd42667331;
                5'd5: r = 34'sd21354465;
                5'd6: r = 34'sd10679838;
                5'd7: r = 34'sd5340245;
                5'd8: r = 34'sd2670163;
                5'd9: r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/tfms_datapath.sv =====
module tfms_datapath #(
    parameter int MAX_MODES  = tfms_pkg::MAX_MODES_DEF,
    parameter int ANGLE_BITS = tfms_pkg::ANGLE_BITS_DEF,
    parameter int IDX_W      = $clog2(MAX_MODES)
) (
    input  logic                  clk,
    input  tfms_pkg::tfms_cmd_t   cmd,
    output tfms_pkg::tfms_status_t status,
    input  logic [IDX_W-1:0]      rd_idx,
    input  logic                  wr_en,
    input  logic [1:0]            wr_kind,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic signed [31:0]    in_x,
    input  logic signed [31:0]    in_y,
    input  logic signed [31:0]    in_z,
    input  logic [15:0]           in_phase,
    output logic signed [31:0]    out_x,
    output logic signed [31:0]    out_y,
    output logic signed [31:0]    out_z
);
    import tfms_pkg::*;

    logic [95:0] wave_mem  [MAX_MODES];
    logic [15:0] phase_mem [MAX_MODES];
    logic [95:0] pol1_mem  [MAX_MODES];
    logic [95:0] pol2_mem  [MAX_MODES];

    logic [95:0] wave_q_reg, pol1_q_reg, pol2_q_reg;
    logic [15:0] phase_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            unique case (wr_kind)
                KIND_WAVE:
                begin
                    wave_mem[wr_idx]  <= {in_z, in_y, in_x};
                    phase_mem[wr_idx] <= in_phase;
                end
                KIND_POL1:  pol1_mem[wr_idx] <= {in_z, in_y, in_x};
                KIND_POL2:  pol2_mem[wr_idx] <= {in_z, in_y, in_x};
                KIND_QUERY: ;
            endcase
        end
        if (cmd.rd_en)
        begin
            wave_q_reg  <= wave_mem[rd_idx];
            phase_q_reg <= phase_mem[rd_idx];
            pol1_q_reg  <= pol1_mem[rd_idx];
            pol2_q_reg  <= pol2_mem[rd_idx];
        end
    end

    logic signed [31:0] pos_reg [3];
    logic [31:0] prod_reg [3];
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [4:0] step_reg;
    logic neg_reg;
    logic signed [63:0] acc_reg [3];
    logic signed [63:0] term_reg [3];
    logic signed [31:0] out_reg [3];

    logic [31:0] dot_lo;
    logic [ANGLE_BITS-1:0] ph_s, ang;
    logic [31:0] turn, turn_adj;
    logic quad;
    logic signed [33:0] dx, dy;

    always_comb
    begin
        dot_lo   = prod_reg[0] + prod_reg[1] + prod_reg[2];
        ph_s     = ANGLE_BITS'({phase_q_reg, 8'd0} >> (24 - ANGLE_BITS));
        ang      = ANGLE_BITS'(dot_lo >> (32 - ANGLE_BITS)) + ph_s;
        turn     = {ang, {(32 - ANGLE_BITS){1'b0}}};
        quad     = (turn + 32'h4000_0000) >= 32'h8000_0000;
        turn_adj = quad ? turn + 32'h8000_0000 : turn;
        dx       = cy_reg >>> step_reg;
        dy       = cx_reg >>> step_reg;
    end

    assign status.last_step = (step_reg == 5'(CORDIC_STEPS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load_pos)
        begin
            pos_reg[0] <= in_x;
            pos_reg[1] <= in_y;
            pos_reg[2] <= in_z;
        end
        if (cmd.clear)
        begin
            for (int j = 0; j < 3; j++)
                acc_reg[j] <= '0;
        end
        for (int j = 0; j < 3; j++)
        begin
            if (cmd.mode_start)
                prod_reg[j] <= 32'($signed(wave_q_reg[32*j +: 32]) * pos_reg[j]);
        end
        if (cmd.cordic_init)
        begin
            cx_reg   <= CORDIC_ONE;
            cy_reg   <= '0;
            cz_reg   <= 34'($signed(turn_adj));
            neg_reg  <= quad;
            step_reg <= 5'd0;
        end
        else if (cmd.cordic_step)
        begin
            if (cz_reg >= 0)
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - atan_turns(step_reg);
            end
            else
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + atan_turns(step_reg);
            end
            step_reg <= step_reg + 5'd1;
        end
        if (cmd.term_calc)
        begin
            for (int j = 0; j < 3; j++)
                term_reg[j] <= (neg_reg ? -cx_reg : cx_reg) * $signed(pol1_q_reg[32*j +: 32])
                             - (neg_reg ? -cy_reg : cy_reg) * $signed(pol2_q_reg[32*j +: 32]);
        end
        if (cmd.acc_add)
        begin
            for (int j = 0; j < 3; j++)
                acc_reg[j] <= acc_reg[j] + (term_reg[j] >>> 30);
        end
        if (cmd.sat_out)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (acc_reg[j] > 64'sd2147483647)
                    out_reg[j] <= 32'sh7fff_ffff;
                else if (acc_reg[j] < -64'sd2147483648)
                    out_reg[j] <= 32'sh8000_0000;
                else
                    out_reg[j] <= acc_reg[j][31:0];
            end
        end
    end

    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];

endmodule

// ===== rtl/core/tfms_ctrl.sv =====
module tfms_ctrl #(
    parameter int MAX_MODES = tfms_pkg::MAX_MODES_DEF,
    parameter int IDX_W     = $clog2(MAX_MODES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          query,
    output logic                          busy,
    input  logic [tfms_pkg::MODES_W-1:0]  modes_in_use,
    input  tfms_pkg::tfms_status_t        status,
    output tfms_pkg::tfms_cmd_t           cmd,
    output logic [IDX_W-1:0]              rd_idx,
    output logic                          done
);
    import tfms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DOT, S_INIT, S_ROT, S_TERM, S_ACC, S_SAT
    } state_t;

    state_t state_reg;
    logic [10:0] mode_reg, n_reg;
    logic [10:0] n_lim;

    assign n_lim = (11'(modes_in_use) > 11'(MAX_MODES)) ? 11'(MAX_MODES) : 11'(modes_in_use);
    assign rd_idx = mode_reg[IDX_W-1:0];
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        cmd.clear       = (state_reg == S_IDLE) && query;
        cmd.load_pos    = (state_reg == S_IDLE) && query;
        cmd.rd_en       = (state_reg == S_READ);
        cmd.mode_start  = (state_reg == S_DOT);
        cmd.cordic_init = (state_reg == S_INIT);
        cmd.cordic_step = (state_reg == S_ROT);
        cmd.term_calc   = (state_reg == S_TERM);
        cmd.acc_add     = (state_reg == S_ACC);
        cmd.sat_out     = (state_reg == S_SAT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= '0;
            n_reg     <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (query)
                    begin
                        mode_reg  <= '0;
                        n_reg     <= n_lim;
                        state_reg <= (n_lim == 11'd0) ? S_SAT : S_READ;
                    end
                S_READ: state_reg <= S_DOT;
                S_DOT:  state_reg <= S_INIT;
                S_INIT: state_reg <= S_ROT;
                S_ROT:  if (status.last_step) state_reg <= S_TERM;
                S_TERM: state_reg <= S_ACC;
                S_ACC:
                begin
                    mode_reg  <= mode_reg + 11'd1;
                    state_reg <= (mode_reg + 11'd1 == n_reg) ? S_SAT : S_READ;
                end
                S_SAT:
                begin
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/turbulent_field_mode_sum.sv =====
// channel   dir  fields (tdata low bit up)                        tuser
// s_axis    in   mode_index, vector_x, vector_y, vector_z, phase  kind
// m_axis    out  field_x, field_y, field_z                       -
// cfg       in   modes_in_use on cfg_wdata                       -
// a load is written when accepted; a query raises m_axis_tvalid after each mode in use passes through
// read, dot, init, the 24-step cordic rotation shared by all modes, term and acc states, then sat
// rst_n sets modes_in_use to 1 and idles control; tables stay undefined until loaded
// a result waiting on m_axis_tready blocks the next request
module turbulent_field_mode_sum #(
    parameter int MAX_MODES  = tfms_pkg::MAX_MODES_DEF,
    parameter int ANGLE_BITS = tfms_pkg::ANGLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // mode_index, vector_x, vector_y, vector_z, phase_turns, pad
    input  logic [1:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // field_x, field_y, field_z
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata
);
    import tfms_pkg::*;

    localparam int IDX_W = $clog2(MAX_MODES);

    logic [MODES_W-1:0] modes_reg;
    logic acc, busy, done, valid_reg, query, wr_en;
    tfms_cmd_t cmd;
    tfms_status_t status;
    logic [IDX_W-1:0] rd_idx;
    logic [5:0] idx6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modes_reg <= MODES_W'(1);
        else if (cfg_we)
            modes_reg <= cfg_wdata;
    end

    assign s_axis_tready = !busy && !done && !valid_reg;
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign query = acc && (s_axis_tuser == KIND_QUERY);
    assign idx6  = s_axis_tdata[5:0];
    assign wr_en = acc && (s_axis_tuser != KIND_QUERY) && (32'(idx6) < MAX_MODES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (done)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end
    assign m_axis_tvalid = valid_reg;

    tfms_ctrl #(.MAX_MODES(MAX_MODES), .IDX_W(IDX_W)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .query(query), .busy(busy),
        .modes_in_use(modes_reg), .status(status), .cmd(cmd),
        .rd_idx(rd_idx), .done(done)
    );

    tfms_datapath #(.MAX_MODES(MAX_MODES), .ANGLE_BITS(ANGLE_BITS), .IDX_W(IDX_W)) u_dp (
        .clk(clk), .cmd(cmd), .status(status), .rd_idx(rd_idx),
        .wr_en(wr_en), .wr_kind(s_axis_tuser), .wr_idx(IDX_W'(idx6)),
        .in_x(s_axis_tdata[37:6]), .in_y(s_axis_tdata[69:38]),
        .in_z(s_axis_tdata[101:70]), .in_phase(s_axis_tdata[117:102]),
        .out_x(m_axis_tdata[31:0]), .out_y(m_axis_tdata[63:32]),
        .out_z(m_axis_tdata[95:64])
    );

endmodule

// ===== dv/turbulent_field_mode_sum_checker.sv =====
module turbulent_field_mode_sum_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    output int           failures,
    output int           fields_waiting,
    output int           queries_seen
);
    import tfms_pkg::*;

    localparam int NMODES = 64;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
    } field_t;

    logic signed [31:0] wave_k [NMODES][3];
    logic [15:0]        mode_phase [NMODES];
    logic signed [31:0] pol_vec [NMODES][6];
    logic [6:0]         modes_sel;
    field_t             field_fifo [$];

    longint rot_angle [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    task automatic rotate(input logic [31:0] turn, output longint cv, output longint sv);
        logic   flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (((turn + 32'h4000_0000) & 32'h8000_0000) != 0)
        begin
            turn = turn + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(turn));
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - rot_angle[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + rot_angle[i];
            end
        end
        cv = flip ? -x : x;
        sv = flip ? -y : y;
    endtask

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    task automatic sum_field(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] pz, output field_t f);
        longint      acc [3];
        longint      pos [3];
        logic [63:0] dot;
        logic [15:0] ang;
        longint      cv;
        longint      sv;
        longint      t;
        int          n;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        acc = '{0, 0, 0};
        n = (modes_sel > NMODES) ? NMODES : modes_sel;
        for (int m = 0; m < n; m++)
        begin
            dot = 0;
            for (int j = 0; j < 3; j++)
                dot = dot + 64'(longint'(wave_k[m][j]) * pos[j]);
            ang = dot[31:16] + mode_phase[m];
            rotate({ang, 16'h0}, cv, sv);
            for (int j = 0; j < 3; j++)
            begin
                t = cv * longint'(pol_vec[m][j]) - sv * longint'(pol_vec[m][3 + j]);
                acc[j] = acc[j] + (t >>> 30);
            end
        end
        f.fx = clamp32(acc[0]);
        f.fy = clamp32(acc[1]);
        f.fz = clamp32(acc[2]);
    endtask

    task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endtask

    assign fields_waiting = field_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        field_t f;
        logic [5:0] idx;
        if (!rst_n)
        begin
            modes_sel = 7'd1;
            field_fifo.delete();
            failures = 0;
            queries_seen = 0;
        end
        else
        begin
            if (cfg_we)
                modes_sel = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                idx = s_axis_tdata[5:0];
                case (s_axis_tuser)
                    KIND_WAVE:
                    begin
                        wave_k[idx][0] = s_axis_tdata[37:6];
                        wave_k[idx][1] = s_axis_tdata[69:38];
                        wave_k[idx][2] = s_axis_tdata[101:70];
                        mode_phase[idx] = s_axis_tdata[117:102];
                    end
                    KIND_POL1, KIND_POL2:
                    begin
                        for (int j = 0; j < 3; j++)
                            pol_vec[idx][(s_axis_tuser == KIND_POL2 ? 3 : 0) + j] =
                                s_axis_tdata[6 + 32 * j +: 32];
                    end
                    default:
                    begin
                        sum_field(s_axis_tdata[37:6], s_axis_tdata[69:38],
                                  s_axis_tdata[101:70], f);
                        field_fifo = {field_fifo, f};
                        queries_seen++;
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (field_fifo.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result, expected none actual %h", $time,
                             m_axis_tdata);
                end
                else
                begin
                    f = field_fifo.pop_front();
                    compare("field_x", f.fx, m_axis_tdata[31:0]);
                    compare("field_y", f.fy, m_axis_tdata[63:32]);
                    compare("field_z", f.fz, m_axis_tdata[95:64]);
                end
            end
        end
    end

endmodule

// ===== dv/turbulent_field_mode_sum_test.sv =====
module turbulent_field_mode_sum_test;
    import tfms_pkg::*;

    localparam int LIMIT = 12000000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = KIND_WAVE;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [6:0]   cfg_wdata = 7'd1;
    int           failures;
    int           fields_waiting;
    int           queries_seen;
    int           cycle_count = 0;
    logic         calm = 1'b0;
    int           requests_sent = 0;

    always #2 clk = ~clk;

    turbulent_field_mode_sum dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    turbulent_field_mode_sum_checker field_check (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .failures(failures), .fields_waiting(fields_waiting), .queries_seen(queries_seen)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("turbulent_field_mode_sum verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 31);

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'($urandom_range(131071)) - 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic [1:0] kind, input logic [5:0] idx, input logic [31:0] vx,
                        input logic [31:0] vy, input logic [31:0] vz, input logic [15:0] ph);
        while (!calm && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {2'b00, ph, vz, vy, vx, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic send_random(input logic [1:0] kind, input logic [5:0] idx);
        send(kind, idx, pick_value(), pick_value(), pick_value(), 16'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (fields_waiting != 0)
            @(posedge clk);
        repeat (2100) @(posedge clk);
    endtask

    task automatic set_modes(input logic [6:0] n);
        cfg_we <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    logic [6:0] mode_choices [8] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd2, 7'd3, 7'd5, 7'd8};

    initial
    begin
        int n;
        int qpct;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: entry 0 plus one write to entry 63, extremes of every field
        set_modes(7'd1);
        send(KIND_WAVE, 6'd0, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
        send(KIND_POL1, 6'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 16'hffff);
        send(KIND_POL2, 6'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 16'h0);
        send(KIND_QUERY, 6'd63, 32'h0, 32'h0, 32'h0, 16'hffff);
        send(KIND_QUERY, 6'd0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'h0);
        send(KIND_QUERY, 6'd21, 32'h0000_4000, 32'h0000_8000, 32'h0, 16'h1234);
        send(KIND_WAVE, 6'd0, 32'h0, 32'h0, 32'h0, 16'h4000);
        send(KIND_QUERY, 6'd0, 32'h1, 32'h1, 32'h1, 16'h0);
        send(KIND_WAVE, 6'd0, 32'h0, 32'h0, 32'h0, 16'hc000);
        send(KIND_QUERY, 6'd0, 32'h1, 32'h1, 32'h1, 16'h0);
        send(KIND_WAVE, 6'd0, 32'h0, 32'h0, 32'h0, 16'h0);
        send(KIND_POL1, 6'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 16'h5555);
        send(KIND_POL2, 6'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 16'haaaa);
        send(KIND_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 16'h0);
        send(KIND_POL1, 6'd63, 32'h1, 32'h2, 32'h3, 16'hffff);
        drain();
        set_modes(7'd0);
        send(KIND_QUERY, 6'd5, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
        drain();

        // fill the whole table, then run phases over several mode counts
        for (int m = 0; m < 64; m++)
        begin
            send_random(KIND_WAVE, 6'(m));
            send_random(KIND_POL1, 6'(m));
            send_random(KIND_POL2, 6'(m));
        end
        drain();
        for (int p = 0; p < 12; p++)
        begin
            calm <= (p == 4);
            if (p < 8)
                n = mode_choices[p];
            else
                n = $urandom_range(1, 12);
            set_modes(7'(n));
            qpct = (n > 16) ? 20 : 45;
            repeat ((n > 16) ? 60 : 120)
            begin
                if ($urandom_range(99) < qpct)
                    send_random(KIND_QUERY, 6'($urandom));
                else
                    send_random(2'($urandom_range(2)), 6'($urandom));
            end
            drain();
        end
        calm <= 1'b0;

        $display("sent %0d requests, %0d of them queries, over mode counts 0 to 127",
                 requests_sent, queries_seen);
        if (failures == 0)
            $display("turbulent_field_mode_sum verification clean");
        else
            $display("turbulent_field_mode_sum verification failed");
        $finish;
    end

endmodule
